// ===== hw/rtl/tagged_slot_allocator_assert.svh =====
// Assertion macros shared by the slot allocator RTL.
`ifndef TAGGED_SLOT_ALLOCATOR_ASSERT_SVH
`define TAGGED_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TSA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tagged_slot_allocator assertion failed");
`define TSA_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("tagged_slot_allocator assertion failed");
`else
`define TSA_ASSERT(lbl, clk, rst_n, prop)
`define TSA_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)
`endif
`endif

// ===== hw/rtl/tsa_pkg.sv =====
// Types and codes shared by the slot allocator modules.
package tsa_pkg;

    localparam int KEY_W = 64;
    localparam int COORD_W = 4;
    localparam int OCC_W = 12;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_SEARCH  = 2'd2;
    localparam logic [1:0] OP_MAP     = 2'd3;

    localparam logic [2:0] STAT_PARKED    = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_RELEASED  = 3'd2;
    localparam logic [2:0] STAT_BAD_COORD = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;
    localparam logic [2:0] STAT_FOUND     = 3'd5;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd6;
    localparam logic [2:0] STAT_MAP       = 3'd7;

    typedef struct packed {
        logic [1:0]         operation;
        logic [KEY_W-1:0]   key_in;
        logic [COORD_W-1:0] row_in;
        logic [COORD_W-1:0] col_in;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [COORD_W-1:0] row_out;
        logic [COORD_W-1:0] col_out;
        logic [KEY_W-1:0]   key_out;
        logic [OCC_W-1:0]   occupancy;
    } t_out;

    // Classified command held in the queue between front and back.
    typedef struct packed {
        logic [1:0]         op;
        logic [KEY_W-1:0]   key;
        logic               coord_ok;
        logic [COORD_W-1:0] row0;
        logic [COORD_W-1:0] col0;
    } t_cmd;

endpackage

// ===== hw/rtl/tsa_ram.sv =====
// Generic RAM: one write port, one read port, registered read data.
module tsa_ram
    #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 12,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
    ) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tsa_front.sv =====
// Front end: accepts commands, checks release coordinates, queues them.
module tsa_front
    import tsa_pkg::*;
    #(
    parameter int NUM_ROWS = 3,
    parameter int NUM_COLS = 4,
    parameter int KEY_BITS = 64
    ) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_cmd,
    output logic o_busy,
    output logic o_q_valid,
    output t_cmd o_q_cmd,
    input  logic i_q_pop
);

    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KEY_BITS) - KEY_W'(1));

    t_cmd       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    t_cmd       cls;

    assign o_busy = (r_count == 2'd2);
    assign push   = i_start && !o_busy;

    always_comb begin
        cls.op       = i_cmd.operation;
        cls.key      = i_cmd.key_in & KEY_MASK;
        cls.coord_ok = (i_cmd.row_in != '0) && (i_cmd.row_in <= COORD_W'(NUM_ROWS)) &&
                       (i_cmd.col_in != '0) && (i_cmd.col_in <= COORD_W'(NUM_COLS));
        cls.row0     = i_cmd.row_in - COORD_W'(1);
        cls.col0     = i_cmd.col_in - COORD_W'(1);
    end

    always_comb begin
        n_count = r_count;
        if (push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls;
        end
    end

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_cmd   = r_q[r_rptr];

`include "tagged_slot_allocator_assert.svh"

    `TSA_ASSERT(a_q_count_max, i_clk, i_rst_n, r_count <= 2'd2)
    `TSA_ASSERT(a_pop_needs_entry, i_clk, i_rst_n, i_q_pop |-> o_q_valid)

endmodule

// ===== hw/rtl/tsa_back.sv =====
// Back end: slot scan sequencer, occupancy bits, key store and result register.
module tsa_back
    import tsa_pkg::*;
    #(
    parameter int NUM_ROWS = 3,
    parameter int NUM_COLS = 4,
    parameter int KEY_BITS = 64
    ) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_q_pop,
    output logic o_strobe,
    output t_out o_result
);

    localparam int NUM_SLOTS = NUM_ROWS * NUM_COLS;
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ALLOC  = 2'd1;
    localparam logic [1:0] S_REL_RD = 2'd2;
    localparam logic [1:0] S_SEARCH = 2'd3;

    logic [1:0]          r_state, n_state;
    t_cmd                r_cmd;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [COORD_W-1:0]  r_row, n_row;
    logic [COORD_W-1:0]  r_col, n_col;
    logic                r_pend, n_pend;
    logic [COORD_W-1:0]  r_pend_row, r_pend_col;
    logic [IDX_W-1:0]    r_rel_idx, n_rel_idx;
    logic [NUM_SLOTS-1:0] r_occ, n_occ;
    logic                r_res_valid, n_res_valid;
    t_out                r_res, n_res;
    logic [OCC_W-1:0]    occ_map;

    logic [7:0]          rel_lin;
    logic [IDX_W-1:0]    rel_idx;
    logic [IDX_W-1:0]    scan_idx;
    logic                scan_end;

    logic                ram_we;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    tsa_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (NUM_SLOTS),
        .AW    (IDX_W)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (scan_idx),
        .i_wdata (r_cmd.key[KEY_BITS-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rel_lin  = 8'(i_q_cmd.row0) * 8'(NUM_COLS) + 8'(i_q_cmd.col0);
    assign rel_idx  = rel_lin[IDX_W-1:0];
    assign scan_idx = r_idx[IDX_W-1:0];
    assign scan_end = (r_idx == CNT_W'(NUM_SLOTS));

    // Occupancy reported is the state after the operation, first slots only.
    for (genvar g = 0; g < OCC_W; g++) begin : g_occ
        if (g < NUM_SLOTS) begin : g_slot
            assign occ_map[g] = n_occ[g];
        end else begin : g_none
            assign occ_map[g] = 1'b0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_row       = r_row;
        n_col       = r_col;
        n_pend      = r_pend;
        n_rel_idx   = r_rel_idx;
        n_occ       = r_occ;
        n_res_valid = 1'b0;
        n_res       = '0;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = scan_idx;

        unique case (r_state)
            S_IDLE: begin
                n_idx  = '0;
                n_row  = '0;
                n_col  = '0;
                n_pend = 1'b0;
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.op)
                        OP_ALLOC:  n_state = S_ALLOC;
                        OP_SEARCH: n_state = S_SEARCH;
                        OP_RELEASE: begin
                            if (!i_q_cmd.coord_ok) begin
                                n_res_valid  = 1'b1;
                                n_res.status = STAT_BAD_COORD;
                            end else if (r_occ[rel_idx]) begin
                                ram_re    = 1'b1;
                                ram_raddr = rel_idx;
                                n_rel_idx = rel_idx;
                                n_state   = S_REL_RD;
                            end else begin
                                n_res_valid  = 1'b1;
                                n_res.status = STAT_EMPTY;
                            end
                        end
                        OP_MAP: begin
                            n_res_valid  = 1'b1;
                            n_res.status = STAT_MAP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ALLOC: begin
                if (scan_end) begin
                    n_res_valid  = 1'b1;
                    n_res.status = STAT_FULL;
                    n_state      = S_IDLE;
                end else if (!r_occ[scan_idx]) begin
                    ram_we          = 1'b1;
                    n_occ[scan_idx] = 1'b1;
                    n_res_valid     = 1'b1;
                    n_res.status    = STAT_PARKED;
                    n_res.row_out   = r_row + COORD_W'(1);
                    n_res.col_out   = r_col + COORD_W'(1);
                    n_state         = S_IDLE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                    if (r_col == COORD_W'(NUM_COLS - 1)) begin
                        n_col = '0;
                        n_row = r_row + COORD_W'(1);
                    end else begin
                        n_col = r_col + COORD_W'(1);
                    end
                end
            end
            S_REL_RD: begin
                n_occ[r_rel_idx] = 1'b0;
                n_res_valid      = 1'b1;
                n_res.status     = STAT_RELEASED;
                n_res.key_out    = KEY_W'(ram_rdata);
                n_state          = S_IDLE;
            end
            S_SEARCH: begin
                // Compare the slot read last cycle while the next read goes out.
                if (r_pend && (ram_rdata == r_cmd.key[KEY_BITS-1:0])) begin
                    n_res_valid   = 1'b1;
                    n_res.status  = STAT_FOUND;
                    n_res.row_out = r_pend_row + COORD_W'(1);
                    n_res.col_out = r_pend_col + COORD_W'(1);
                    n_state       = S_IDLE;
                end else if (scan_end) begin
                    n_res_valid  = 1'b1;
                    n_res.status = STAT_NOT_FOUND;
                    n_state      = S_IDLE;
                end else begin
                    n_pend = r_occ[scan_idx];
                    ram_re = r_occ[scan_idx];
                    n_idx  = r_idx + CNT_W'(1);
                    if (r_col == COORD_W'(NUM_COLS - 1)) begin
                        n_col = '0;
                        n_row = r_row + COORD_W'(1);
                    end else begin
                        n_col = r_col + COORD_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_res.occupancy = occ_map;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_row      <= n_row;
        r_col      <= n_col;
        r_pend     <= n_pend;
        r_rel_idx  <= n_rel_idx;
        r_res      <= n_res;
        r_pend_row <= r_row;
        r_pend_col <= r_col;
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    assign o_strobe = r_res_valid;
    assign o_result = r_res;

`include "tagged_slot_allocator_assert.svh"

    `TSA_ASSERT(a_result_ends_cmd, i_clk, i_rst_n, r_res_valid |-> (r_state == S_IDLE))
    `TSA_ASSERT(a_release_occupied, i_clk, i_rst_n, (r_state == S_REL_RD) |-> r_occ[r_rel_idx])
    `TSA_ASSERT_NEXT(a_alloc_sets_slot, i_clk, i_rst_n,
        (r_state == S_ALLOC) && n_res_valid && (n_res.status == STAT_PARKED),
        $countones(r_occ) == $countones($past(r_occ)) + 1)

endmodule

// ===== hw/rtl/tagged_slot_allocator.sv =====
// Top level of the tagged slot allocator: command front end, queue and slot engine.
//
// A command is taken at a rising edge with start high and busy low; a two-entry
// queue holds up to two commands, and busy is high while it is full. Each command
// gives exactly one result, shown on o_result for one cycle with o_strobe high;
// the receiver cannot stall it. After a command leaves the queue, map and bad or
// empty release answer from the idle state, a good release after one key RAM read,
// and allocate and search scan the slots: allocate checks the occupancy bits one
// slot per cycle; search steps one slot per cycle, reads the key RAM for occupied
// slots and compares each read while the next goes out. Commands pass the queue first.
module tagged_slot_allocator
    import tsa_pkg::*;
    #(
    parameter int NUM_ROWS = 3,
    parameter int NUM_COLS = 4,
    parameter int KEY_BITS = 64
    ) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_cmd,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    tsa_front #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS),
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .o_busy    (busy),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    tsa_back #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule
